FILE: design/ir_pulse_train_capture_core_defines.svh
// Assertion macros shared by the checker of the capture core.
`ifndef IR_PULSE_TRAIN_CAPTURE_CORE_DEFINES_SVH
`define IR_PULSE_TRAIN_CAPTURE_CORE_DEFINES_SVH

// Concurrent assertion on clk_i, disabled while reset is low.
`define IPTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("iptc assertion failed");

// Assertion that a condition never holds at a clock edge outside reset.
`define IPTC_ASSERT_NEVER(lbl, cond) \
  `IPTC_ASSERT(lbl, !(cond))

`endif

FILE: design/iptc_pkg.sv
package iptc_pkg;

  // Capture geometry.
  localparam int MAX_SYMBOLS     = 64;
  localparam int SYM_IDX_W       = $clog2(MAX_SYMBOLS);
  localparam int MIN_EDGES       = 12;
  localparam int PAD_DURATION_US = 1000;
  localparam int US_PER_MS       = 1000;

  // Timeout in microseconds: 16 bit milliseconds times one thousand.
  localparam int TIMEOUT_US_W    = 26;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_NOISE_FILTER = 2'd0,
    REG_MAX_DURATION = 2'd1,
    REG_IDLE_GAP     = 2'd2,
    REG_LEARN_TIMEOUT = 2'd3
  } cfg_idx_e;

  // Request codes of an input transaction.
  typedef enum logic {
    REQ_START  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_type_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_RUN,
    ST_TIMEOUT,
    ST_READ,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic        req_type;
    logic        pin_level;
    logic [31:0] time_us;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  sym_pos;
    logic        first_level;
    logic [14:0] first_duration;
    logic        second_level;
    logic [14:0] second_duration;
    logic [6:0]  symbol_count;
    logic [7:0]  edge_count;
    logic        last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sample_en;
    logic rd_start;
    logic rd_issue;
    logic rd_advance;
    logic emit_timeout;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finish;
    logic few_edges;
    logic rd_last;
  } stat_t;

endpackage

FILE: design/iptc_datapath.sv
module iptc_datapath import iptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  input  in_t         in_data_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output out_t        out_data_o
);

  // Configuration registers.
  logic [14:0]             noise_q;
  logic [14:0]             max_dur_q;
  logic [19:0]             idle_q;
  logic [TIMEOUT_US_W-1:0] timeout_us_q;

  // Capture state.
  logic                 active_q, active_d;
  logic                 started_q, started_d;
  logic                 prev_q, prev_d;
  logic [31:0]          last_q, last_d;
  logic [31:0]          start_q, start_d;
  logic [7:0]           edges_q, edges_d;
  logic [SYM_IDX_W-1:0] rd_k_q;

  // Symbol store, split into first and second halves.
  logic [15:0] first_mem  [MAX_SYMBOLS];
  logic [15:0] second_mem [MAX_SYMBOLS];
  logic [15:0] rd_first_q;
  logic [15:0] rd_second_q;

  logic [31:0]          elapsed;
  logic [31:0]          dur;
  logic                 timed_out;
  logic                 gap;
  logic                 chg;
  logic                 qual;
  logic                 add_ok;
  logic [14:0]          clamped;
  logic [SYM_IDX_W-1:0] wr_idx;
  logic                 wr_first;
  logic                 wr_second;
  logic [8:0]           cnt_sum;
  logic [6:0]           sym_count;
  logic                 rd_last;
  logic                 pad;

  // Configuration writes; the timeout is kept in microseconds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_q      <= 15'd100;
      max_dur_q    <= 15'd32767;
      idle_q       <= 20'd20000;
      timeout_us_q <= TIMEOUT_US_W'(10000 * US_PER_MS);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_NOISE_FILTER:  noise_q   <= cfg_data_i[14:0];
        REG_MAX_DURATION:  max_dur_q <= cfg_data_i[14:0];
        REG_IDLE_GAP:      idle_q    <= cfg_data_i;
        REG_LEARN_TIMEOUT: timeout_us_q <= TIMEOUT_US_W'(cfg_data_i[15:0]) *
                                           TIMEOUT_US_W'(US_PER_MS);
        default: ;
      endcase
    end
  end

  // Interval and timeout measurements for the sample at the input.
  always_comb begin
    elapsed   = in_data_i.time_us - start_q;
    dur       = in_data_i.time_us - last_q;
    timed_out = elapsed >= 32'(timeout_us_q);
    gap       = dur > 32'(idle_q);
    chg       = in_data_i.pin_level != prev_q;
    qual      = started_q && (edges_q >= 8'(MIN_EDGES));
    add_ok    = (dur >= 32'(noise_q)) && (edges_q < 8'(2 * MAX_SYMBOLS));
    clamped   = (dur > 32'(max_dur_q)) ? max_dur_q : dur[14:0];
    wr_idx    = edges_q[SYM_IDX_W:1];
  end

  assign stat_o.finish = (in_data_i.req_type == REQ_SAMPLE) && active_q &&
                         (timed_out || (gap && qual));
  assign stat_o.few_edges = edges_q < 8'(MIN_EDGES);

  // Next capture state for an accepted transaction.
  always_comb begin
    active_d  = active_q;
    started_d = started_q;
    prev_d    = prev_q;
    last_d    = last_q;
    start_d   = start_q;
    edges_d   = edges_q;
    wr_first  = 1'b0;
    wr_second = 1'b0;
    if (cmd_i.sample_en) begin
      if (in_data_i.req_type == REQ_START) begin
        active_d  = 1'b1;
        started_d = 1'b0;
        prev_d    = in_data_i.pin_level;
        last_d    = in_data_i.time_us;
        start_d   = in_data_i.time_us;
        edges_d   = '0;
      end else if (active_q) begin
        if (stat_o.finish) begin
          active_d = 1'b0;
        end else if (chg) begin
          if (gap) begin
            edges_d   = '0;
            started_d = 1'b0;
          end else if (add_ok) begin
            wr_first  = !edges_q[0];
            wr_second = edges_q[0];
            edges_d   = edges_q + 8'd1;
            started_d = 1'b1;
          end
          prev_d = in_data_i.pin_level;
          last_d = in_data_i.time_us;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      started_q <= 1'b0;
      prev_q    <= 1'b1;
      last_q    <= '0;
      start_q   <= '0;
      edges_q   <= '0;
      rd_k_q    <= '0;
    end else begin
      active_q  <= active_d;
      started_q <= started_d;
      prev_q    <= prev_d;
      last_q    <= last_d;
      start_q   <= start_d;
      edges_q   <= edges_d;
      if (cmd_i.rd_start) begin
        rd_k_q <= '0;
      end else if (cmd_i.rd_advance) begin
        rd_k_q <= rd_k_q + SYM_IDX_W'(1);
      end
    end
  end

  // Store writes and the registered readout port. A first half write
  // also clears the second half of that symbol.
  always_ff @(posedge clk_i) begin
    if (wr_first) begin
      first_mem[wr_idx]  <= {~prev_q, clamped};
      second_mem[wr_idx] <= '0;
    end else if (wr_second) begin
      second_mem[wr_idx] <= {~prev_q, clamped};
    end
    if (cmd_i.rd_issue) begin
      rd_first_q  <= first_mem[rd_k_q];
      rd_second_q <= second_mem[rd_k_q];
    end
  end

  // Frame length in symbols, limited to the store depth.
  always_comb begin
    cnt_sum   = {1'b0, edges_q} + 9'd1;
    sym_count = (edges_q >= 8'(2 * MAX_SYMBOLS)) ? 7'(MAX_SYMBOLS) : cnt_sum[7:1];
    rd_last   = (7'(rd_k_q) + 7'd1) == sym_count;
    pad       = rd_last && (rd_second_q[14:0] == 15'd0);
  end

  assign stat_o.rd_last = rd_last;

  // Result payload: either the timeout status or one stored symbol.
  always_comb begin
    out_data_o            = '0;
    out_data_o.edge_count = edges_q;
    if (cmd_i.emit_timeout) begin
      out_data_o.status = 1'b1;
      out_data_o.last   = 1'b1;
    end else begin
      out_data_o.sym_pos         = 6'(rd_k_q);
      out_data_o.first_level     = rd_first_q[15];
      out_data_o.first_duration  = rd_first_q[14:0];
      out_data_o.second_level    = pad ? 1'b0 : rd_second_q[15];
      out_data_o.second_duration = pad ? 15'(PAD_DURATION_US) : rd_second_q[14:0];
      out_data_o.symbol_count    = sym_count;
      out_data_o.last            = rd_last;
    end
  end

endmodule

FILE: design/iptc_ctrl.sv
module iptc_ctrl import iptc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // Sample intake, then the readout walk or a timeout status when a capture finishes.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_RUN: begin
        in_stall_o      = 1'b0;
        cmd_o.sample_en = in_valid_i;
        if (in_valid_i && stat_i.finish) begin
          if (stat_i.few_edges) begin
            state_d = ST_TIMEOUT;
          end else begin
            cmd_o.rd_start = 1'b1;
            state_d        = ST_READ;
          end
        end
      end
      ST_TIMEOUT: begin
        out_valid_o        = 1'b1;
        cmd_o.emit_timeout = 1'b1;
        if (!out_stall_i) begin
          state_d = ST_RUN;
        end
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (stat_i.rd_last) begin
            state_d = ST_RUN;
          end else begin
            cmd_o.rd_advance = 1'b1;
            state_d          = ST_READ;
          end
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

endmodule

FILE: design/ir_pulse_train_capture_core.sv
// Infrared pulse train capture core.
// Input channel (in_valid_i, in_stall_o, in_data_i): a start transaction opens a
// learning session with the idle receiver level and time; sample transactions
// carry timestamped receiver levels. Transactions are taken back to back while no
// frame or timeout status is offered. Output channel (out_valid_o, out_stall_i,
// out_data_o): when a capture finishes, the core emits one transaction per stored
// symbol, or a single timeout status. The timeout status appears in the cycle
// after the finishing sample. A frame's first symbol follows the ST_READ state,
// which issues the registered store read, and each further symbol again passes
// a store read in ST_READ and an output in ST_EMIT. The input stalls for the
// whole readout. A stalled result holds its payload, and the readout waits on it.
// The configuration port (cfg_we_i, cfg_index_i, cfg_data_i) is to be written by
// the user only while the core is idle; the core itself does not enforce it.
// Reset restores the default register values and closes any session; the
// symbol store is not cleared and needs no clearing pass.
module ir_pulse_train_capture_core import iptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer for intake and readout.
  iptc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Measurement, capture state and symbol store.
  iptc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/iptc_checker.sv
`include "ir_pulse_train_capture_core_defines.svh"

module iptc_checker import iptc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_t        out_data_o
);

  logic       timeout_ok;
  logic       frame_end;
  logic [6:0] last_pos;

  // Shape of the final transactions.
  assign timeout_ok = out_data_o.last && (out_data_o.symbol_count == 7'd0);
  assign frame_end  = out_valid_o && !out_data_o.status && out_data_o.last;
  assign last_pos   = {1'b0, out_data_o.sym_pos} + 7'd1;

  // A stalled result transaction stays offered and unchanged.
  `IPTC_ASSERT(a_out_valid_holds, out_valid_o && out_stall_i |=> out_valid_o)
  `IPTC_ASSERT(a_out_data_holds, out_valid_o && out_stall_i |=> $stable(out_data_o))

  // No input transaction is taken while a result is offered.
  `IPTC_ASSERT_NEVER(a_no_intake_in_readout, out_valid_o && !in_stall_o)

  // A timeout status is a single, final transaction without symbols.
  `IPTC_ASSERT(a_timeout_shape, out_valid_o && out_data_o.status |-> timeout_ok)

  // The final symbol of a frame sits at the last position of the frame.
  `IPTC_ASSERT(a_last_sym_pos, frame_end |-> (last_pos == out_data_o.symbol_count))

endmodule

bind ir_pulse_train_capture_core iptc_checker u_iptc_checker (.*);

FILE: sim/ir_pulse_train_capture_core_tb.sv
module ir_pulse_train_capture_core_tb;
  import iptc_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 16;
  localparam int TARGET_ITEMS    = 450;

  // Predicts the symbols of each learned frame and checks the emitted results.
  class frame_checker;
    bit [14:0]   noise_filter;
    bit [14:0]   max_duration;
    bit [19:0]   idle_gap;
    bit [15:0]   timeout_ms;
    bit          active;
    bit          started;
    bit          prev_level;
    bit [31:0]   last_change;
    bit [31:0]   session_start;
    int unsigned edges;
    bit [31:0]   store [MAX_SYMBOLS];
    out_t        pending_symbols [$];
    int unsigned failures;

    function new();
      noise_filter  = 15'd100;
      max_duration  = 15'd32767;
      idle_gap      = 20'd20000;
      timeout_ms    = 16'd10000;
      active        = 1'b0;
      prev_level    = 1'b1;
      last_change   = '0;
      session_start = '0;
      failures      = 0;
      clear_capture();
    endfunction

    function void write_reg(cfg_idx_e idx, bit [19:0] value);
      case (idx)
        REG_NOISE_FILTER:  noise_filter = value[14:0];
        REG_MAX_DURATION:  max_duration = value[14:0];
        REG_IDLE_GAP:      idle_gap     = value;
        REG_LEARN_TIMEOUT: timeout_ms   = value[15:0];
        default: ;
      endcase
    endfunction

    function void clear_capture();
      edges   = 0;
      started = 1'b0;
      foreach (store[i]) store[i] = '0;
    endfunction

    // Close the session and queue either the frame or a timeout status.
    function void finish_frame();
      out_t        r;
      int unsigned count;
      bit [31:0]   w;
      active = 1'b0;
      if (edges < MIN_EDGES) begin
        r            = '0;
        r.status     = 1'b1;
        r.edge_count = 8'(edges);
        r.last       = 1'b1;
        pending_symbols.push_back(r);
        return;
      end
      count = (edges + 1) / 2;
      if (count > MAX_SYMBOLS) count = MAX_SYMBOLS;
      // An empty last half is padded, and its level cleared with it.
      if (store[count-1][14:0] == 15'd0) store[count-1][15:0] = 16'(PAD_DURATION_US);
      for (int unsigned k = 0; k < count; k++) begin
        w                 = store[k];
        r.status          = 1'b0;
        r.sym_pos         = 6'(k);
        r.first_level     = w[31];
        r.first_duration  = w[30:16];
        r.second_level    = w[15];
        r.second_duration = w[14:0];
        r.symbol_count    = 7'(count);
        r.edge_count      = 8'(edges);
        r.last            = (k + 1 == count);
        pending_symbols.push_back(r);
      end
    endfunction

    // Update the capture state with one accepted input transaction.
    function void take_transaction(in_t item);
      bit [31:0]   dur;
      bit [31:0]   elapsed;
      bit [14:0]   kept;
      int unsigned idx;
      if (item.req_type == REQ_START) begin
        active        = 1'b1;
        prev_level    = item.pin_level;
        last_change   = item.time_us;
        session_start = item.time_us;
        clear_capture();
        return;
      end
      if (!active) return;

      // The session timeout is checked before the level.
      elapsed = item.time_us - session_start;
      if (elapsed >= 32'(timeout_ms) * 32'(US_PER_MS)) begin
        finish_frame();
        return;
      end

      if (item.pin_level != prev_level) begin
        dur = item.time_us - last_change;
        if (dur > 32'(idle_gap)) begin
          if (started && edges >= MIN_EDGES) begin
            finish_frame();
            return;
          end
          clear_capture();
        end else if (dur >= 32'(noise_filter) && edges / 2 < MAX_SYMBOLS) begin
          kept = (dur > 32'(max_duration)) ? max_duration : dur[14:0];
          idx  = edges / 2;
          if (edges % 2 == 0) store[idx] = {~prev_level, kept, 16'h0000};
          else store[idx][15:0] = {~prev_level, kept};
          edges++;
          started = 1'b1;
        end
        prev_level  = item.pin_level;
        last_change = item.time_us;
      end

      // A quiet gap after enough edges ends the capture.
      if (started && edges >= MIN_EDGES && (item.time_us - last_change) > 32'(idle_gap))
        finish_frame();
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    // Check one result transaction against the oldest predicted symbol.
    function void check_symbol(out_t got);
      out_t want;
      if (pending_symbols.size() == 0) begin
        $error("result transaction with nothing pending, sym_pos %0d",
               got.sym_pos);
        failures++;
        return;
      end
      want = pending_symbols.pop_front();
      compare("status", 32'(want.status), 32'(got.status));
      compare("sym_pos", 32'(want.sym_pos), 32'(got.sym_pos));
      compare("first_level", 32'(want.first_level), 32'(got.first_level));
      compare("first_duration", 32'(want.first_duration), 32'(got.first_duration));
      compare("second_level", 32'(want.second_level), 32'(got.second_level));
      compare("second_duration", 32'(want.second_duration), 32'(got.second_duration));
      compare("symbol_count", 32'(want.symbol_count), 32'(got.symbol_count));
      compare("edge_count", 32'(want.edge_count), 32'(got.edge_count));
      compare("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [19:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_t         in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_t        out_data_o;

  frame_checker learn_check;

  // Stimulus view of the receiver line and of the current register values.
  bit [31:0]   now_us;
  bit          rx_level;
  bit [14:0]   cfg_noise;
  bit [19:0]   cfg_idle;
  bit [15:0]   cfg_timeout;
  bit          tx_steady;
  bit          hold_off_req;
  int unsigned items_sent;

  ir_pulse_train_capture_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Clock with a period of 8.
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Offer one transaction, with a random gap before it, and wait for acceptance.
  task automatic send_item(req_type_e req, bit lvl);
    in_t         item;
    int unsigned gap;
    int unsigned pick;
    item.req_type  = req;
    item.pin_level = lvl;
    item.time_us   = now_us;
    gap = 0;
    if (!tx_steady) begin
      pick = $urandom_range(0, 99);
      if (pick >= 97) gap = $urandom_range(8, 40);
      else if (pick >= 70) gap = $urandom_range(1, 3);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    learn_check.take_transaction(item);
    items_sent++;
  endtask

  task automatic open_session(bit lvl);
    rx_level = lvl;
    now_us   = $urandom();
    send_item(REQ_START, lvl);
  endtask

  task automatic send_sample(bit toggle, int unsigned delta);
    now_us = now_us + delta;
    if (toggle) rx_level = ~rx_level;
    send_item(REQ_SAMPLE, rx_level);
  endtask

  // Write all four registers while the core is idle.
  task automatic set_config(bit [19:0] noise, bit [19:0] max_dur, bit [19:0] idle,
                            bit [19:0] tmo);
    cfg_idx_e  regs [4];
    bit [19:0] vals [4];
    regs = '{REG_NOISE_FILTER, REG_MAX_DURATION, REG_IDLE_GAP, REG_LEARN_TIMEOUT};
    vals = '{noise, max_dur, idle, tmo};
    cfg_noise   = noise[14:0];
    cfg_idle    = idle;
    cfg_timeout = tmo[15:0];
    foreach (regs[i]) begin
      @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      learn_check.write_reg(regs[i], vals[i]);
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every predicted result has arrived and the core has gone quiet.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (learn_check.pending_symbols.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // A well-formed session: a start, a train of pulses and one of several endings.
  task automatic learn_frame(int unsigned n_edges);
    int unsigned lo;
    int unsigned hi;
    int unsigned cap;
    int unsigned pick;
    int unsigned delta;
    lo = 32'(cfg_noise);
    hi = (cfg_idle > lo) ? cfg_idle : lo;
    pick = $urandom_range(0, 2);
    cap = (pick == 0) ? 40 : (pick == 1) ? 300 : 3000;
    tx_steady = ($urandom_range(0, 3) == 0);
    open_session(1'($urandom_range(0, 1)));
    repeat (n_edges) begin
      pick = $urandom_range(0, 99);
      if (pick < 8 && cfg_noise > 0) delta = $urandom_range(0, cfg_noise - 1);
      else if (pick < 10) delta = cfg_idle + $urandom_range(1, 50);
      else if (pick < 40) delta = $urandom_range(lo, hi);
      else delta = lo + $urandom_range(0, (hi - lo < cap) ? hi - lo : cap);
      send_sample(1'b1, delta);
      if ($urandom_range(0, 9) == 0) send_sample(1'b0, $urandom_range(0, cfg_idle));
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) send_sample(1'b0, cfg_idle + $urandom_range(1, 500));
    else if (pick < 85) send_sample(1'b1, cfg_idle + $urandom_range(1, 500));
    else if (pick < 95)
      send_sample(1'($urandom_range(0, 1)),
                  32'(cfg_timeout) * 1000 + $urandom_range(0, 100));
  endtask

  // Unstructured transactions: stray starts, random levels and wild time jumps.
  task automatic noise_burst(int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) open_session(1'($urandom_range(0, 1)));
      else if (pick < 30) send_sample(1'($urandom_range(0, 1)), $urandom());
      else send_sample(1'($urandom_range(0, 1)), $urandom_range(0, 2 * cfg_idle + 1));
    end
  endtask

  // Receiver: random stalls, quiet stretches and one long hold-off on request.
  initial begin : rx_side
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned pick;
    bit          rx_steady;
    stall_left  = 0;
    hold_left   = 0;
    mode_left   = 0;
    rx_steady   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode_left = $urandom_range(50, 300);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      mode_left--;
      if (hold_off_req && hold_left == 0 && out_valid_o) begin
        hold_left    = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (rx_steady) begin
        out_stall_i <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_stall_i <= 1'b0;
        end else begin
          stall_left = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 50);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  // Every accepted result transaction is checked at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) learn_check.check_symbol(out_data_o);
  end

  // Watchdog on the cycle count.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** ir_pulse_train_capture_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned n_frames;
    int unsigned pick;
    int unsigned directed_us [13];
    directed_us = '{100, 20000, 562, 1687, 562, 562, 1687, 562, 562, 1687, 562, 562,
                    9000};
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = REG_NOISE_FILTER;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    hold_off_req = 1'b0;
    tx_steady    = 1'b0;
    items_sent   = 0;
    now_us       = '0;
    rx_level     = 1'b1;
    cfg_noise    = 15'd100;
    cfg_idle     = 20'd20000;
    cfg_timeout  = 16'd10000;
    learn_check  = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a sample with no session, a restart during a session, a noise
    // pulse, the noise and idle bounds met exactly, a padded last half, a
    // quiet-gap finish and a sample after the finish.
    send_sample(1'b1, 5);
    open_session(1'b1);
    send_sample(1'b1, 500);
    send_sample(1'b1, 600);
    open_session(1'b0);
    send_sample(1'b1, 50);
    foreach (directed_us[i]) send_sample(1'b1, directed_us[i]);
    send_sample(1'b0, 20001);
    send_sample(1'b1, 10);
    settle();

    // Directed: a zero timeout register makes the first sample time out.
    set_config(100, 32767, 20000, 0);
    open_session(1'b1);
    send_sample(1'b1, 300);
    settle();

    // Random phases, each with its own register setting.
    phase = 0;
    while (items_sent < TARGET_ITEMS) begin
      case (phase)
        0: set_config(100, 32767, 20000, 10000);
        1: set_config(0, 20'h7FFF, 20'hFFFFF, 20'hFFFF);
        2: set_config(20'h7FFF, 20'h7FFF, 20'hFFFFF, 10000);
        3: set_config(50, 400, 3000, 1);
        4: set_config(0, 0, 0, 5);
        5: set_config(0, 32767, 3000, 2);
        default:
          set_config({5'($urandom), 15'($urandom_range(0, 300))},
                     {5'($urandom), 15'($urandom_range(1, 32767))},
                     20'($urandom_range(1, 60000)),
                     {4'($urandom), 16'($urandom_range(1, 200))});
      endcase
      // A full store read out against a long receiver hold-off.
      if (phase == 1) begin
        hold_off_req = 1'b1;
        learn_frame(132);
      end
      n_frames = $urandom_range(2, 5);
      repeat (n_frames) begin
        noise_burst($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 10) learn_frame($urandom_range(3, 11));
        else if (pick < 98) learn_frame($urandom_range(12, 30));
        else learn_frame($urandom_range(128, 134));
      end
      settle();
      phase++;
    end

    if (learn_check.failures == 0 && learn_check.pending_symbols.size() == 0) begin
      $display("** ir_pulse_train_capture_core: PASSED **");
    end else begin
      $display("** ir_pulse_train_capture_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/iptc_pkg.sv
design/iptc_datapath.sv
design/iptc_ctrl.sv
design/ir_pulse_train_capture_core.sv
design/iptc_checker.sv
sim/ir_pulse_train_capture_core_tb.sv
